FILE: rtl/stt_pkg.sv
// Shared types and constants for the transposition table.
// Used by the front end, the back end, the top level and the testbench; it depends on nothing else.
package stt_pkg;

    localparam logic [1:0] FuncStore  = 2'd0;
    localparam logic [1:0] FuncProbe  = 2'd1;
    localparam logic [1:0] FuncQprobe = 2'd2;
    localparam logic [1:0] FuncClear  = 2'd3;

    localparam logic [1:0] KindNone  = 2'd0;
    localparam logic [1:0] KindExact = 2'd1;
    localparam logic [1:0] KindUpper = 2'd2;
    localparam logic [1:0] KindLower = 2'd3;

    localparam int MateEdge = 256;

    localparam int unsigned MidAw = 1;
    localparam int unsigned OutAw = 2;

    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic [7:0]         ply;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [31:0]        move;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_item;

    typedef struct packed {
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [31:0]        move;
    } t_entry;

    typedef struct packed {
        logic signed [15:0] score;
        logic               hit;
        logic [31:0]        move;
    } t_result;

endpackage

FILE: rtl/stt_fifo.sv
// Small first-in first-out queue of register entries.
// Generic in width and depth; it depends on no package.
module stt_fifo #(
    parameter int unsigned W  = 8,
    parameter int unsigned AW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output logic          o_empty,
    output logic [AW:0]   o_count
);

    localparam int unsigned Depth = 2 ** AW;

    logic [W-1:0] r_mem [Depth];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW:0]   r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW + 1)'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/stt_front.sv
// Front end: registers each accepted beat and applies the mate adjustment to stored scores.
// Depends on stt_pkg; feeds the queue in front of the back end.
module stt_front #(
    parameter int MATE_SCORE = 30000
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stt_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_busy,
    output logic            o_vld,
    output stt_pkg::t_item  o_item,
    input  logic            i_mid_full
);

    localparam logic signed [16:0] MateHi = 17'(MATE_SCORE - stt_pkg::MateEdge);
    localparam logic signed [16:0] MateLo = -MateHi;
    localparam logic signed [16:0] ScoreMax = 17'sd32767;
    localparam logic signed [16:0] ScoreMin = -17'sd32768;

    logic           r_vld;
    stt_pkg::t_item r_item;
    stt_pkg::t_item n_item;
    logic signed [16:0] s_wide;
    logic signed [16:0] s_up;
    logic signed [16:0] s_dn;
    logic           accept;

    assign o_full = (r_vld && i_mid_full) || i_busy;
    assign accept = i_push && !o_full;
    assign o_vld  = r_vld;
    assign o_item = r_item;

    always_comb begin
        s_wide = {i_item.score[15], i_item.score};
        s_up   = s_wide + $signed({9'd0, i_item.ply});
        s_dn   = s_wide - $signed({9'd0, i_item.ply});
        n_item = i_item;
        if (i_item.func == stt_pkg::FuncStore) begin
            if (s_wide >= MateHi) begin
                n_item.score = (s_up > ScoreMax) ? 16'sd32767 : s_up[15:0];
            end else if (s_wide <= MateLo) begin
                n_item.score = (s_dn < ScoreMin) ? -16'sd32768 : s_dn[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (!i_mid_full) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/stt_back.sv
// Back end: holds the table memory, carries out stores, probes and the clearing sweep.
// Depends on stt_pkg; takes beats from the middle queue and feeds the result queue.
module stt_back #(
    parameter int INDEX_BITS    = 16,
    parameter int MATE_SCORE    = 30000,
    parameter int UNKNOWN_SCORE = 32767
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_vld,
    input  stt_pkg::t_item                i_head,
    output logic                          o_head_pop,
    input  logic [stt_pkg::OutAw:0]       i_out_count,
    output logic                          o_res_vld,
    output stt_pkg::t_result              o_res,
    output logic                          o_busy
);

    localparam int unsigned Slots = 2 ** INDEX_BITS;
    localparam int unsigned OutDepth = 2 ** stt_pkg::OutAw;
    localparam logic signed [15:0] MateHi = 16'(MATE_SCORE - stt_pkg::MateEdge);
    localparam logic signed [15:0] MateLo = -MateHi;
    localparam logic signed [15:0] Unknown = 16'(UNKNOWN_SCORE);

    stt_pkg::t_entry r_mem [Slots];
    stt_pkg::t_entry r_rd;
    stt_pkg::t_item  r_s1;
    logic            r_s1_vld;
    logic            r_clearing;
    logic [INDEX_BITS-1:0] r_clr_cnt;

    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] waddr;
    stt_pkg::t_entry       wdata;
    stt_pkg::t_entry       clr_entry;
    logic                  we;
    logic                  head_probe;
    logic                  credit;
    logic                  issue_probe;
    logic [stt_pkg::OutAw+1:0] in_flight;

    logic                  hit;
    logic signed [15:0]    s;
    logic signed [15:0]    s_adj;
    logic                  upper_cut;
    logic                  lower_cut;
    logic signed [15:0]    res_score;

    assign idx        = i_head.key[INDEX_BITS-1:0];
    assign head_probe = (i_head.func == stt_pkg::FuncProbe) ||
                        (i_head.func == stt_pkg::FuncQprobe);
    assign in_flight  = {1'b0, i_out_count} + (stt_pkg::OutAw + 2)'(r_s1_vld);
    assign credit     = in_flight < (stt_pkg::OutAw + 2)'(OutDepth);
    assign o_head_pop = i_head_vld && !r_clearing && (!head_probe || credit);
    assign issue_probe = o_head_pop && head_probe;
    assign o_busy     = r_clearing;

    always_comb begin
        clr_entry       = '0;
        clr_entry.score = Unknown;
        we    = r_clearing || (o_head_pop && (i_head.func == stt_pkg::FuncStore));
        waddr = r_clearing ? r_clr_cnt : idx;
        if (r_clearing) begin
            wdata = clr_entry;
        end else begin
            wdata.key   = i_head.key;
            wdata.depth = i_head.depth;
            wdata.score = i_head.score;
            wdata.kind  = i_head.kind;
            wdata.move  = i_head.move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_probe) begin
            r_rd <= r_mem[idx];
            r_s1 <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            r_s1_vld <= issue_probe;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (&r_clr_cnt) begin
                    r_clearing <= 1'b0;
                end
            end else if (o_head_pop && (i_head.func == stt_pkg::FuncClear)) begin
                r_clearing <= 1'b1;
                r_clr_cnt  <= '0;
            end
        end
    end

    always_comb begin
        hit       = (r_rd.key == r_s1.key);
        s         = r_rd.score;
        upper_cut = (r_rd.kind == stt_pkg::KindUpper) && (s <= r_s1.alpha);
        lower_cut = (r_rd.kind == stt_pkg::KindLower) && (s >= r_s1.beta);
        if (s >= MateHi) begin
            s_adj = s - $signed({8'd0, r_s1.ply});
        end else if (s <= MateLo) begin
            s_adj = s + $signed({8'd0, r_s1.ply});
        end else begin
            s_adj = s;
        end
        res_score = Unknown;
        if (hit) begin
            if (r_s1.func == stt_pkg::FuncProbe) begin
                if ((r_rd.depth >= r_s1.depth) &&
                    ((r_rd.kind == stt_pkg::KindExact) || upper_cut || lower_cut)) begin
                    res_score = s_adj;
                end
            end else begin
                priority if (r_rd.kind == stt_pkg::KindExact) begin
                    res_score = s;
                end else if (upper_cut) begin
                    res_score = r_s1.alpha;
                end else if (lower_cut) begin
                    res_score = r_s1.beta;
                end
            end
        end
        o_res.score = res_score;
        o_res.hit   = hit;
        o_res.move  = hit ? r_rd.move : 32'd0;
    end

    assign o_res_vld = r_s1_vld;

endmodule

FILE: rtl/search_transposition_table.sv
// Top level of the direct-mapped transposition table.
// Depends on stt_pkg, stt_front, stt_fifo and stt_back.
//
// Channel   Direction  Handshake           Beat
// input     in         push / full         func, key, depth, ply, score, kind, move, window
// result    out        pop / empty         probe score, key hit, hit move
//
// Stores and probes issue one per cycle from the middle queue into the single table memory
// unless a clear is running. A probe result is registered in the front end, the middle
// queue and the back end before it reaches the result queue. A clear sweeps one entry per
// cycle over all 2**INDEX_BITS entries with full held high; the same sweep runs after reset.
// A full result queue stalls probes at the head of the middle queue; stores still drain.
module search_transposition_table #(
    parameter int INDEX_BITS    = 16,
    parameter int MATE_SCORE    = 30000,
    parameter int UNKNOWN_SCORE = 32767
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_func,
    input  logic [63:0]        i_hash_key,
    input  logic [7:0]         i_search_depth,
    input  logic [7:0]         i_ply_from_root,
    input  logic signed [15:0] i_store_score,
    input  logic [1:0]         i_bound_kind,
    input  logic [31:0]        i_best_move,
    input  logic signed [15:0] i_alpha_bound,
    input  logic signed [15:0] i_beta_bound,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_probe_score,
    output logic               o_key_hit,
    output logic [31:0]        o_hit_move
);

    localparam int unsigned ItemW = $bits(stt_pkg::t_item);
    localparam int unsigned ResW  = $bits(stt_pkg::t_result);

    stt_pkg::t_item   in_item;
    stt_pkg::t_item   front_item;
    stt_pkg::t_item   head_item;
    stt_pkg::t_result res;
    stt_pkg::t_result out_res;
    logic             front_vld;
    logic             mid_full;
    logic             mid_empty;
    logic [stt_pkg::MidAw:0] mid_count;
    logic             head_pop;
    logic             busy;
    logic             res_vld;
    logic             out_full;
    logic [stt_pkg::OutAw:0] out_count;
    logic [ItemW-1:0] head_bits;
    logic [ResW-1:0]  out_bits;

    always_comb begin
        in_item.func  = i_func;
        in_item.key   = i_hash_key;
        in_item.depth = i_search_depth;
        in_item.ply   = i_ply_from_root;
        in_item.score = i_store_score;
        in_item.kind  = i_bound_kind;
        in_item.move  = i_best_move;
        in_item.alpha = i_alpha_bound;
        in_item.beta  = i_beta_bound;
    end

    stt_front #(
        .MATE_SCORE (MATE_SCORE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (in_item),
        .o_full     (full),
        .i_busy     (busy),
        .o_vld      (front_vld),
        .o_item     (front_item),
        .i_mid_full (mid_full)
    );

    stt_fifo #(
        .W  (ItemW),
        .AW (stt_pkg::MidAw)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_item),
        .o_full  (mid_full),
        .i_pop   (head_pop),
        .o_data  (head_bits),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign head_item = stt_pkg::t_item'(head_bits);

    stt_back #(
        .INDEX_BITS    (INDEX_BITS),
        .MATE_SCORE    (MATE_SCORE),
        .UNKNOWN_SCORE (UNKNOWN_SCORE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_vld  (!mid_empty && (mid_count != '0)),
        .i_head      (head_item),
        .o_head_pop  (head_pop),
        .i_out_count (out_count),
        .o_res_vld   (res_vld),
        .o_res       (res),
        .o_busy      (busy)
    );

    stt_fifo #(
        .W  (ResW),
        .AW (stt_pkg::OutAw)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld && !out_full),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_bits),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign out_res       = stt_pkg::t_result'(out_bits);
    assign o_probe_score = out_res.score;
    assign o_key_hit     = out_res.hit;
    assign o_hit_move    = out_res.move;

endmodule

FILE: rtl/stt_checker.sv
// Port-level checks for the transposition table, bound to the top level.
// Depends only on the ports of search_transposition_table.
module stt_checker #(
    parameter int UNKNOWN_SCORE = 32767
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] o_probe_score,
    input logic               o_key_hit,
    input logic [31:0]        o_hit_move
);

    localparam logic signed [15:0] Unknown = 16'(UNKNOWN_SCORE);

    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("full is low right after reset although the table sweep runs");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("a result beat is shown right after reset");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_key_hit) |-> ((o_probe_score == Unknown) && (o_hit_move == 32'd0)))
        else $error("a key miss carries a score or a move");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_probe_score) && $stable(o_key_hit) &&
                              $stable(o_hit_move)))
        else $error("a waiting result beat changed or vanished");

endmodule

bind search_transposition_table stt_checker #(
    .UNKNOWN_SCORE (UNKNOWN_SCORE)
) u_stt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_probe_score (o_probe_score),
    .o_key_hit     (o_key_hit),
    .o_hit_move    (o_hit_move)
);

FILE: sim/stt_checker.sv
// Checker for the transposition table: watches the input and result queues, keeps its own
// copy of the table, predicts every probe answer and compares it with the returned beat.
// Depends on stt_pkg for the item, entry and result types and the function and kind codes.
module tb_checker #(
    parameter int INDEX_BITS    = 16,
    parameter int MATE_SCORE    = 30000,
    parameter int UNKNOWN_SCORE = 32767
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [1:0]         i_func,
    input  logic [63:0]        i_hash_key,
    input  logic [7:0]         i_search_depth,
    input  logic [7:0]         i_ply_from_root,
    input  logic signed [15:0] i_store_score,
    input  logic [1:0]         i_bound_kind,
    input  logic [31:0]        i_best_move,
    input  logic signed [15:0] i_alpha_bound,
    input  logic signed [15:0] i_beta_bound,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [15:0] i_probe_score,
    input  logic               i_key_hit,
    input  logic [31:0]        i_hit_move,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    stt_pkg::t_entry  table_slots [int unsigned];
    stt_pkg::t_result probe_answers [$];
    stt_pkg::t_item   seen_beat;
    stt_pkg::t_result predicted;
    stt_pkg::t_result wanted;

    function automatic int saturate16(input int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic stt_pkg::t_entry slot_read(input int unsigned idx);
        stt_pkg::t_entry blank;
        if (table_slots.exists(idx)) begin
            return table_slots[idx];
        end
        blank = '{key: '0, depth: '0, score: 16'(UNKNOWN_SCORE), kind: stt_pkg::KindNone,
                  move: '0};
        return blank;
    endfunction

    // Applies one accepted beat to the table copy; returns 1 when the beat yields an answer.
    function automatic bit table_access(input stt_pkg::t_item it,
                                        output stt_pkg::t_result answer);
        int unsigned     idx;
        stt_pkg::t_entry ent;
        int              s;
        int              ply;
        int              alpha;
        int              beta;
        bit              upper_cut;
        bit              lower_cut;
        idx    = 32'(it.key[INDEX_BITS-1:0]);
        ply    = int'(it.ply);
        s      = int'(it.score);
        alpha  = int'(it.alpha);
        beta   = int'(it.beta);
        answer = '{score: 16'(UNKNOWN_SCORE), hit: 1'b0, move: '0};
        case (it.func)
            stt_pkg::FuncClear: begin
                table_slots.delete();
                return 1'b0;
            end
            stt_pkg::FuncStore: begin
                if (s >= MATE_SCORE - stt_pkg::MateEdge) begin
                    s = saturate16(s + ply);
                end else if (s <= stt_pkg::MateEdge - MATE_SCORE) begin
                    s = saturate16(s - ply);
                end
                table_slots[idx] = '{key: it.key, depth: it.depth, score: 16'(s),
                                     kind: it.kind, move: it.move};
                return 1'b0;
            end
            default: begin
            end
        endcase
        ent = slot_read(idx);
        if (ent.key == it.key) begin
            s           = int'(ent.score);
            upper_cut   = (ent.kind == stt_pkg::KindUpper) && (s <= alpha);
            lower_cut   = (ent.kind == stt_pkg::KindLower) && (s >= beta);
            answer.hit  = 1'b1;
            answer.move = ent.move;
            if (it.func == stt_pkg::FuncProbe) begin
                if (int'(ent.depth) >= int'(it.depth) &&
                    (ent.kind == stt_pkg::KindExact || upper_cut || lower_cut)) begin
                    if (s >= MATE_SCORE - stt_pkg::MateEdge) begin
                        s = s - ply;
                    end else if (s <= stt_pkg::MateEdge - MATE_SCORE) begin
                        s = s + ply;
                    end
                    answer.score = 16'(s);
                end
            end else if (ent.kind == stt_pkg::KindExact) begin
                answer.score = 16'(s);
            end else if (upper_cut) begin
                answer.score = 16'(alpha);
            end else if (lower_cut) begin
                answer.score = 16'(beta);
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_slots.delete();
            probe_answers.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (probe_answers.size() == 0) begin
                    $error("result beat with no probe waiting: score %0d, hit %0d, move %0h",
                           i_probe_score, i_key_hit, i_hit_move);
                    o_fail_count++;
                end else begin
                    wanted = probe_answers.pop_front();
                    if (i_probe_score !== wanted.score) begin
                        $error("probe_score: expected %0d, got %0d", wanted.score,
                               i_probe_score);
                        o_fail_count++;
                    end
                    if (i_key_hit !== wanted.hit) begin
                        $error("key_hit: expected %0d, got %0d", wanted.hit, i_key_hit);
                        o_fail_count++;
                    end
                    if (i_hit_move !== wanted.move) begin
                        $error("hit_move: expected %0h, got %0h", wanted.move, i_hit_move);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                seen_beat = '{func: i_func, key: i_hash_key, depth: i_search_depth,
                              ply: i_ply_from_root, score: i_store_score, kind: i_bound_kind,
                              move: i_best_move, alpha: i_alpha_bound, beta: i_beta_bound};
                if (table_access(seen_beat, predicted)) begin
                    probe_answers.push_back(predicted);
                end
            end
        end
        o_pending <= probe_answers.size();
    end

endmodule

FILE: sim/tb.sv
// Top of the transposition table testbench: clock, reset, stimulus, result popping and verdict.
// Depends on stt_pkg, the search_transposition_table block and the tb_checker module.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IndexBits     = 16;
    localparam int MateScore     = 30000;
    localparam int UnknownScore  = 32767;
    localparam int WatchdogLimit = 300000;
    localparam int PhaseBeats    = 250;
    localparam int PoolSize      = 16;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               push    = 1'b0;
    logic               pop     = 1'b0;
    logic               full;
    logic               empty;
    stt_pkg::t_item     in_beat = '0;
    logic signed [15:0] probe_score;
    logic               key_hit;
    logic [31:0]        hit_move;
    int                 fail_count;
    int                 pending;

    int                 send_idle_pct = 0;
    int                 pop_stall_pct = 0;
    int                 hold_off      = 0;
    int                 clears_left   = 2;
    logic [63:0]        key_pool [PoolSize];

    search_transposition_table #(
        .INDEX_BITS   (IndexBits),
        .MATE_SCORE   (MateScore),
        .UNKNOWN_SCORE(UnknownScore)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (in_beat.func),
        .i_hash_key     (in_beat.key),
        .i_search_depth (in_beat.depth),
        .i_ply_from_root(in_beat.ply),
        .i_store_score  (in_beat.score),
        .i_bound_kind   (in_beat.kind),
        .i_best_move    (in_beat.move),
        .i_alpha_bound  (in_beat.alpha),
        .i_beta_bound   (in_beat.beta),
        .empty          (empty),
        .pop            (pop),
        .o_probe_score  (probe_score),
        .o_key_hit      (key_hit),
        .o_hit_move     (hit_move)
    );

    tb_checker #(
        .INDEX_BITS   (IndexBits),
        .MATE_SCORE   (MateScore),
        .UNKNOWN_SCORE(UnknownScore)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_func         (in_beat.func),
        .i_hash_key     (in_beat.key),
        .i_search_depth (in_beat.depth),
        .i_ply_from_root(in_beat.ply),
        .i_store_score  (in_beat.score),
        .i_bound_kind   (in_beat.kind),
        .i_best_move    (in_beat.move),
        .i_alpha_bound  (in_beat.alpha),
        .i_beta_bound   (in_beat.beta),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_probe_score  (probe_score),
        .i_key_hit      (key_hit),
        .i_hit_move     (hit_move),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic stt_pkg::t_item beat_of(input logic [1:0] func, input logic [63:0] key,
                                               input int depth, input int ply,
                                               input int score, input logic [1:0] kind,
                                               input logic [31:0] move, input int alpha,
                                               input int beta);
        stt_pkg::t_item it;
        it = '{func: func, key: key, depth: 8'(depth), ply: 8'(ply), score: 16'(score),
               kind: kind, move: move, alpha: 16'(alpha), beta: 16'(beta)};
        return it;
    endfunction

    function automatic logic [15:0] random_score();
        case ($urandom_range(5))
            0: return 16'($urandom_range(32767, MateScore - stt_pkg::MateEdge - 50));
            1: return 16'(-int'($urandom_range(32768, MateScore - stt_pkg::MateEdge - 50)));
            2: return 16'(MateScore - stt_pkg::MateEdge - int'($urandom_range(1)));
            3: return 16'(stt_pkg::MateEdge - MateScore + int'($urandom_range(1)));
            default: return 16'($urandom);
        endcase
    endfunction

    // Most keys come in pairs that share the table index but differ above it, so that
    // probes see both hits and index collisions. Key zero matches untouched entries.
    task automatic refresh_pool();
        logic [63:0] k;
        for (int i = 0; i < PoolSize; i++) begin
            k = {$urandom, $urandom};
            if (i % 2 == 1) begin
                k[IndexBits-1:0] = key_pool[i-1][IndexBits-1:0];
            end
            key_pool[i] = k;
        end
        key_pool[0] = '0;
        key_pool[2] = '1;
    endtask

    function automatic stt_pkg::t_item random_beat();
        stt_pkg::t_item it;
        int             pick;
        pick     = $urandom_range(99);
        it.func  = (pick < 40) ? stt_pkg::FuncStore
                 : (pick < 72) ? stt_pkg::FuncProbe : stt_pkg::FuncQprobe;
        it.key   = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                            : key_pool[$urandom_range(PoolSize - 1)];
        it.depth = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
        it.ply   = 8'($urandom);
        it.score = random_score();
        it.kind  = 2'($urandom);
        it.move  = $urandom;
        it.alpha = $urandom_range(1) ? random_score() : 16'($urandom);
        it.beta  = $urandom_range(1) ? random_score() : 16'($urandom);
        return it;
    endfunction

    task automatic send_beat(input stt_pkg::t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        in_beat <= it;
        push    <= 1'b1;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        refresh_pool();
        for (int n = 0; n < PhaseBeats; n++) begin
            if (clears_left > 0 && $urandom_range(399) == 0) begin
                clears_left--;
                send_beat(beat_of(stt_pkg::FuncClear, {$urandom, $urandom}, 0, 0, 0,
                                  stt_pkg::KindNone, '0, 0, 0));
            end
            send_beat(random_beat());
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                pop <= 1'b0;
                hold_off--;
            end else begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] k4;
        logic [63:0] k1_alias;
        k1       = 64'h0123_4567_89AB_CDEF;
        k2       = 64'hFEDC_BA98_7654_3210;
        k3       = 64'h8000_0000_0000_0001;
        k4       = 64'h7FFF_FFFF_FFFF_0002;
        k1_alias = {~k1[63:IndexBits], k1[IndexBits-1:0]};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Untouched entries first, then saturation, depth, window cuts, collisions, mate scores and a clear.
        send_beat(beat_of(stt_pkg::FuncProbe, '0, 0, 0, 0,
                          stt_pkg::KindNone, '0, -32768, 32767));
        send_beat(beat_of(stt_pkg::FuncQprobe, '0, 0, 0, 0,
                          stt_pkg::KindNone, '0, 32767, -32768));
        send_beat(beat_of(stt_pkg::FuncProbe, k1, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k1, 255, 255, 32767,
                          stt_pkg::KindExact, '1, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k1, 255, 255, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k2, 10, 200, -32700,
                          stt_pkg::KindExact, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k2, 11, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k2, 10, 100, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncQprobe, k2, 255, 255, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k3, 0, 0, 100,
                          stt_pkg::KindUpper, 32'h1234_5678, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k3, 0, 0, 0,
                          stt_pkg::KindNone, '0, 100, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k3, 0, 0, 0,
                          stt_pkg::KindNone, '0, 99, 0));
        send_beat(beat_of(stt_pkg::FuncQprobe, k3, 0, 0, 0,
                          stt_pkg::KindNone, '0, 150, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k4, 3, 0, -50,
                          stt_pkg::KindLower, 32'hA5A5_A5A5, 0, 0));
        send_beat(beat_of(stt_pkg::FuncQprobe, k4, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, -50));
        send_beat(beat_of(stt_pkg::FuncQprobe, k4, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, -49));
        send_beat(beat_of(stt_pkg::FuncStore, k1_alias, 7, 0, 0,
                          stt_pkg::KindNone, 32'h5A5A_5A5A, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k1_alias, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k1, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k1, 4, 1, MateScore - stt_pkg::MateEdge,
                          stt_pkg::KindExact, '1, 0, 0));
        send_beat(beat_of(stt_pkg::FuncStore, k3, 4, 5, stt_pkg::MateEdge - MateScore,
                          stt_pkg::KindLower, '1, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k3, 4, 9, 0,
                          stt_pkg::KindNone, '0, 0, -32768));
        send_beat(beat_of(stt_pkg::FuncClear, '0, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, k3, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));
        send_beat(beat_of(stt_pkg::FuncProbe, '0, 0, 0, 0,
                          stt_pkg::KindNone, '0, 0, 0));

        random_phase(0, 0);
        random_phase(84, 0);
        random_phase(0, 84);
        random_phase(6, 6);
        hold_off = 400;
        random_phase(0, 0);

        @(negedge i_clk);
        push <= 1'b0;
        pop_stall_pct = 0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/stt_pkg.sv
rtl/stt_fifo.sv
rtl/stt_front.sv
rtl/stt_back.sv
rtl/search_transposition_table.sv
rtl/stt_checker.sv
sim/stt_checker.sv
sim/tb.sv
